[hdl/acrf_pkg.sv]
// package: types, constants and register decode for the codec register file
`timescale 1ns / 1ps

package acrf_pkg;

    localparam int NUM_SLOTS = 19;
    localparam int SLOT_W    = 5;

    typedef logic [SLOT_W-1:0] t_slot;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_WARM  = 2'd2;

    // bank slots with fixed uses outside the generic read path
    localparam t_slot SLOT_PS   = 5'd15;
    localparam t_slot SLOT_GPIO = 5'd16;

    localparam logic [15:0] ID_VALUE    = 16'h1990;
    localparam logic [15:0] RATE_VALUE  = 16'hBB80;
    localparam logic [15:0] VENDOR_ID1  = 16'h4352;
    localparam logic [15:0] VENDOR_ID2  = 16'h5913;

    typedef enum logic [1:0] {
        RS_CONST,
        RS_STORED,
        RS_STATUS,
        RS_MIRROR
    } t_rd_sel;

    typedef enum logic [1:0] {
        WS_IGNORE,
        WS_STORE,
        WS_DEFAULTS
    } t_wr_sel;

    typedef struct packed {
        logic        modelled;
        t_rd_sel     rd_sel;
        t_wr_sel     wr_sel;
        t_slot       slot;
        logic [15:0] const_val;
    } t_reg_info;

    typedef struct packed {
        logic [1:0]  action;
        logic [6:0]  reg_index;
        logic [15:0] write_data;
        logic        link_up;
    } t_req;

    typedef struct packed {
        logic [15:0] read_data;
        logic        unmodelled_access;
        logic        dac_ready;
        logic        adc_ready;
        logic        link_powered;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_ctl_state;

    function automatic t_reg_info f_stored(input t_slot slot);
        t_reg_info info;
        info.modelled  = 1'b1;
        info.rd_sel    = RS_STORED;
        info.wr_sel    = WS_STORE;
        info.slot      = slot;
        info.const_val = 16'h0000;
        return info;
    endfunction

    function automatic t_reg_info f_fixed(input logic [15:0] value);
        t_reg_info info;
        info.modelled  = 1'b1;
        info.rd_sel    = RS_CONST;
        info.wr_sel    = WS_IGNORE;
        info.slot      = '0;
        info.const_val = value;
        return info;
    endfunction

    // byte index with bit 0 already cleared
    function automatic t_reg_info f_decode(input logic [6:0] idx);
        t_reg_info info;
        info.modelled  = 1'b0;
        info.rd_sel    = RS_CONST;
        info.wr_sel    = WS_IGNORE;
        info.slot      = '0;
        info.const_val = 16'h0000;
        case (idx)
            7'h00: begin
                info        = f_fixed(ID_VALUE);
                info.wr_sel = WS_DEFAULTS;
            end
            7'h02: info = f_stored(5'd0);
            7'h04: info = f_stored(5'd1);
            7'h06: info = f_stored(5'd2);
            7'h0A: info = f_stored(5'd3);
            7'h0C: info = f_stored(5'd4);
            7'h0E: info = f_stored(5'd5);
            7'h10: info = f_stored(5'd6);
            7'h12: info = f_stored(5'd7);
            7'h14: info = f_stored(5'd8);
            7'h16: info = f_stored(5'd9);
            7'h18: info = f_stored(5'd10);
            7'h1A: info = f_stored(5'd11);
            7'h1C: info = f_stored(5'd12);
            7'h20: info = f_stored(5'd13);
            7'h22: info = f_stored(5'd14);
            7'h26: begin
                info        = f_stored(SLOT_PS);
                info.rd_sel = RS_STATUS;
            end
            7'h28: begin
                info        = f_fixed(16'h0000);
                info.rd_sel = RS_MIRROR;
            end
            7'h2A: info = f_fixed(16'h0000);
            7'h2C: info = f_fixed(RATE_VALUE);
            7'h32: info = f_fixed(RATE_VALUE);
            7'h5E: info = f_stored(SLOT_GPIO);
            7'h60: info = f_stored(5'd17);
            7'h68: info = f_stored(5'd18);
            7'h7C: info = f_fixed(VENDOR_ID1);
            7'h7E: info = f_fixed(VENDOR_ID2);
            default: ;
        endcase
        return info;
    endfunction

    function automatic logic [15:0] f_default(input t_slot slot);
        logic [15:0] v;
        case (slot)
            5'd0, 5'd1, 5'd2, 5'd12:            v = 16'h8000;
            5'd4, 5'd5:                         v = 16'h8008;
            5'd6, 5'd7, 5'd8, 5'd9, 5'd10:      v = 16'h8808;
            5'd16:                              v = 16'h0080;
            5'd17:                              v = 16'h0023;
            default:                            v = 16'h0000;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] f_wr_mask(input t_slot slot);
        logic [15:0] m;
        case (slot)
            5'd0, 5'd1:                         m = 16'hBF3F;
            5'd2:                               m = 16'h803F;
            5'd3:                               m = 16'h801E;
            5'd4:                               m = 16'h801F;
            5'd5:                               m = 16'h805F;
            5'd6, 5'd7, 5'd8, 5'd9, 5'd10:      m = 16'h9F1F;
            5'd11:                              m = 16'h0707;
            5'd12:                              m = 16'h8F0F;
            5'd13:                              m = 16'h2380;
            5'd14:                              m = 16'h000F;
            5'd15:                              m = 16'hFF00;
            5'd16:                              m = 16'h01B0;
            5'd17:                              m = 16'h0001;
            5'd18:                              m = 16'hCFFF;
            default:                            m = 16'h0000;
        endcase
        return m;
    endfunction

    // reserved bits that always read back as 1
    function automatic logic [15:0] f_wr_set(input t_slot slot);
        logic [15:0] s;
        case (slot)
            5'd17:   s = 16'h0022;
            default: s = 16'h0000;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] f_power_status(input logic [7:0] ctl, input logic link);
        logic rdy_ref;
        logic rdy_anl;
        logic rdy_dac;
        logic rdy_adc;
        rdy_ref = link && (ctl[5:3] == 3'b000);
        rdy_anl = rdy_ref && !ctl[2];
        rdy_dac = rdy_anl && !ctl[1];
        rdy_adc = rdy_anl && !ctl[0];
        return {ctl, 4'b0000, rdy_ref, rdy_anl, rdy_dac, rdy_adc};
    endfunction

endpackage

[hdl/acrf_req_if.sv]
// valid/ready channel carrying one register access request
`timescale 1ns / 1ps

interface acrf_req_if;
    logic            valid;
    logic            ready;
    acrf_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/acrf_rsp_if.sv]
// valid/ready channel carrying one register access response
`timescale 1ns / 1ps

interface acrf_rsp_if;
    logic            valid;
    logic            ready;
    acrf_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/acrf_ctrl.sv]
// controller: sequences accept and execute, owns the response valid flag
`timescale 1ns / 1ps

module acrf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output acrf_pkg::t_dp_cmd o_cmd
);

    acrf_pkg::t_ctl_state r_state;
    acrf_pkg::t_ctl_state n_state;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            acrf_pkg::ST_IDLE: begin
                if (i_in_valid && in_ready) begin
                    n_state = acrf_pkg::ST_EXEC;
                end
            end
            acrf_pkg::ST_EXEC: n_state = acrf_pkg::ST_IDLE;
            default:           n_state = acrf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            acrf_pkg::ST_IDLE: begin
                // output slot is free by the next edge if empty or being taken now
                in_ready   = !r_out_valid || i_out_ready;
                o_cmd.load = i_in_valid && in_ready;
            end
            acrf_pkg::ST_EXEC: o_cmd.exec = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acrf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

[hdl/acrf_datapath.sv]
// datapath: request latch, register bank, decode and response register
`timescale 1ns / 1ps

module acrf_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  acrf_pkg::t_dp_cmd i_cmd,
    input  acrf_pkg::t_req    i_req,
    output acrf_pkg::t_rsp    o_rsp
);

    logic [1:0]           r_action;
    logic [6:0]           r_index;
    logic [15:0]          r_wdata;
    logic                 r_link;
    logic [15:0]          r_bank [acrf_pkg::NUM_SLOTS];
    logic [15:0]          n_bank [acrf_pkg::NUM_SLOTS];
    acrf_pkg::t_rsp       r_rsp;
    acrf_pkg::t_rsp       n_rsp;
    acrf_pkg::t_reg_info  info;
    logic [15:0]          rd_val;
    logic                 bad;
    logic [15:0]          ps_after;

    always_comb begin
        info   = acrf_pkg::f_decode({r_index[6:1], 1'b0});
        n_bank = r_bank;
        rd_val = 16'h0000;
        bad    = 1'b0;
        case (r_action)
            acrf_pkg::ACT_READ: begin
                if (!info.modelled) begin
                    bad = 1'b1;
                end else begin
                    case (info.rd_sel)
                        acrf_pkg::RS_CONST:  rd_val = info.const_val;
                        acrf_pkg::RS_STORED: rd_val = r_bank[info.slot];
                        acrf_pkg::RS_STATUS: rd_val = acrf_pkg::f_power_status(
                                                 r_bank[acrf_pkg::SLOT_PS][15:8], r_link);
                        // rate lock bit mirrors bit 7 of the gpio register
                        acrf_pkg::RS_MIRROR: rd_val = {6'b0, r_bank[acrf_pkg::SLOT_GPIO][7],
                                                       9'b0};
                        default:             rd_val = 16'h0000;
                    endcase
                end
            end
            acrf_pkg::ACT_WRITE: begin
                if (!info.modelled) begin
                    bad = 1'b1;
                end else begin
                    case (info.wr_sel)
                        acrf_pkg::WS_STORE: begin
                            n_bank[info.slot] = (r_wdata & acrf_pkg::f_wr_mask(info.slot))
                                              | acrf_pkg::f_wr_set(info.slot);
                        end
                        acrf_pkg::WS_DEFAULTS: begin
                            for (int i = 0; i < acrf_pkg::NUM_SLOTS; i++) begin
                                n_bank[i] = acrf_pkg::f_default(acrf_pkg::t_slot'(i));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            acrf_pkg::ACT_WARM: n_bank[acrf_pkg::SLOT_PS][12] = 1'b0;
            default: ;
        endcase

        ps_after                = acrf_pkg::f_power_status(
                                      n_bank[acrf_pkg::SLOT_PS][15:8], r_link);
        n_rsp.read_data         = rd_val;
        n_rsp.unmodelled_access = bad;
        n_rsp.dac_ready         = ps_after[1];
        n_rsp.adc_ready         = ps_after[0];
        n_rsp.link_powered      = (n_bank[acrf_pkg::SLOT_PS][13:12] == 2'b00);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_req.action;
            r_index  <= i_req.reg_index;
            r_wdata  <= i_req.write_data;
            r_link   <= i_req.link_up;
        end
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < acrf_pkg::NUM_SLOTS; i++) begin
                r_bank[i] <= acrf_pkg::f_default(acrf_pkg::t_slot'(i));
            end
        end else if (i_cmd.exec) begin
            r_bank <= n_bank;
        end
    end

    assign o_rsp = r_rsp;

endmodule

[hdl/audio_codec_register_file_core.sv]
// top level of the audio codec register file
`timescale 1ns / 1ps

// Register file of an AC'97-style codec. Each request transaction is a read, a
// write or a warm reset; each produces exactly one response transaction with the
// read value, an unmodelled-index flag and the power status ready bits as they
// stand after the access. A request is latched at its accepting edge and executed
// against the flop register bank in the following cycle, which writes the response
// register and raises the response valid flag; the controller accepts no new
// request until that execute state is over. The response sits in its own
// register and the next request is accepted no earlier than the edge at which the
// waiting response is taken, so a stalled response holds off the request side.
// Writing index 00h restores every register to its default value within the same
// execute cycle.
module audio_codec_register_file_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    acrf_req_if.sink   i_req,
    acrf_rsp_if.source o_rsp
);

    acrf_pkg::t_dp_cmd cmd;

    acrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    acrf_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req.data),
        .o_rsp   (o_rsp.data)
    );

    // only one transaction in flight
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is executing");

    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> ##2 o_rsp.valid)
        else $error("no response two cycles after a request");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("request taken while the response slot is blocked");

    a_bad_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.unmodelled_access) |-> (o_rsp.data.read_data == 16'h0000))
        else $error("unmodelled access returned non-zero data");

endmodule
